/* hw/rtl/dfd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfd_pkg
// Shared types and constants of the duplicate frame detector: register
// indexes, reset values, field widths and the group result record.
// ----------------------------------------------------------------------------
package dfd_pkg;

  // Default geometry limits (top-level parameter defaults)
  localparam int MAX_ROW_BYTES_DEF = 8192;
  localparam int MAX_ROWS_DEF      = 4096;
  localparam int MAX_GROUP_DEF     = 25;

  // Register widths
  localparam int GROUP_SIZE_W  = 5;
  localparam int ROW_BYTES_W   = 14;
  localparam int FRAME_ROWS_W  = 13;
  localparam int NOISE_W       = 8;
  localparam int BLEND_W       = 17;
  localparam int CFG_DATA_W    = 17;
  localparam int CFG_INDEX_W   = 3;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_GROUP_SIZE  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ROW_BYTES   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_ROWS  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_NOISE_LEVEL = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_BLEND_LIMIT = 3'd4;

  // Register reset values
  localparam logic [GROUP_SIZE_W-1:0] GROUP_SIZE_RST  = 5'd5;
  localparam logic [ROW_BYTES_W-1:0]  ROW_BYTES_RST   = 14'd720;
  localparam logic [FRAME_ROWS_W-1:0] FRAME_ROWS_RST  = 13'd480;
  localparam logic [NOISE_W-1:0]      NOISE_LEVEL_RST = 8'd15;
  localparam logic [BLEND_W-1:0]      BLEND_LIMIT_RST = 17'd0;

  // Datapath widths
  localparam int PIXEL_W    = 8;
  localparam int DROP_W     = 5;
  localparam int METRIC_W   = 17;
  localparam int COUNT_W    = 23;
  localparam int SCALE_W    = 17;
  localparam int ROWS_CAP_W = 14;  // holds the largest supported MAX_ROWS
  localparam int COLS_CAP_W = 15;  // holds the largest supported MAX_ROW_BYTES
  localparam int NUM_W      = COUNT_W + SCALE_W;
  localparam int DEN_W      = ROWS_CAP_W + COLS_CAP_W;

  localparam logic [SCALE_W-1:0] METRIC_SCALE = 17'd100000;
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [GROUP_SIZE_W-1:0] group_size;
    logic [ROW_BYTES_W-1:0]  row_bytes;
    logic [FRAME_ROWS_W-1:0] frame_rows;
    logic [NOISE_W-1:0]      noise_level;
    logic [BLEND_W-1:0]      blend_limit;
  } cfg_t;

  // One finished group, waiting for its metric
  typedef struct packed {
    logic [COUNT_W-1:0]    lowest_count;
    logic [DROP_W-1:0]     best_index;
    logic [ROWS_CAP_W-1:0] rows;
    logic [COLS_CAP_W-1:0] cols;
    logic [BLEND_W-1:0]    blend_limit;
  } job_t;

  typedef struct packed {
    logic push;
    job_t job;
  } push_t;

  typedef struct packed {
    logic not_empty;
    logic full;
    job_t job;
  } queue_status_t;

  typedef enum logic [1:0] {
    BACK_IDLE,
    BACK_MUL,
    BACK_DIV,
    BACK_DONE
  } back_state_t;

endpackage

/* hw/rtl/dfd_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfd_front
// Takes one byte pair a cycle when accepted, counts noisy sampled pairs per
// frame difference, tracks the lowest one and pushes a record per group.
// ----------------------------------------------------------------------------
module dfd_front #(
  parameter int MAX_ROW_BYTES = dfd_pkg::MAX_ROW_BYTES_DEF,
  parameter int MAX_ROWS      = dfd_pkg::MAX_ROWS_DEF,
  parameter int MAX_GROUP     = dfd_pkg::MAX_GROUP_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  dfd_pkg::cfg_t                cfg,
  input  logic                         accept,
  input  logic [dfd_pkg::PIXEL_W-1:0]  current_pixel,
  input  logic [dfd_pkg::PIXEL_W-1:0]  previous_pixel,
  input  logic                         group_at_start,
  output dfd_pkg::push_t               push
);

  localparam int CW  = $clog2(MAX_ROW_BYTES);
  localparam int CLW = $clog2(MAX_ROW_BYTES + 1);
  localparam int RW  = $clog2(MAX_ROWS);
  localparam int RLW = $clog2(MAX_ROWS + 1);
  localparam int PW  = $clog2(MAX_GROUP);
  localparam int GLW = $clog2(MAX_GROUP + 1);

  logic [CW-1:0]               column_pos;
  logic [RW-1:0]               row_pos;
  logic [PW-1:0]               pair_index;
  logic [dfd_pkg::COUNT_W-1:0] running_count;
  logic [dfd_pkg::COUNT_W-1:0] lowest_count;
  logic [PW-1:0]               best_index;
  logic                        skip_first;

  logic [dfd_pkg::COUNT_W-1:0] lowest_count_next;
  logic [PW-1:0]               best_index_next;
  logic                        skip_first_next;

  logic [CLW-1:0]              cols;
  logic [RLW-1:0]              rows;
  logic [GLW-1:0]              grp;
  logic                        first_byte;
  logic                        skip_eff;
  logic [dfd_pkg::PIXEL_W-1:0] diff;
  logic                        hit;
  logic [dfd_pkg::COUNT_W-1:0] count_inc;
  logic                        row_end;
  logic                        frame_end;
  logic                        group_end;

  // Clamp the geometry registers into the supported range
  always_comb begin
    if (cfg.row_bytes == '0) begin
      cols = CLW'(1);
    end else if (32'(cfg.row_bytes) > 32'(MAX_ROW_BYTES)) begin
      cols = CLW'(MAX_ROW_BYTES);
    end else begin
      cols = CLW'(cfg.row_bytes);
    end
    if (cfg.frame_rows == '0) begin
      rows = RLW'(1);
    end else if (32'(cfg.frame_rows) > 32'(MAX_ROWS)) begin
      rows = RLW'(MAX_ROWS);
    end else begin
      rows = RLW'(cfg.frame_rows);
    end
    if (32'(cfg.group_size) < 32'd2) begin
      grp = GLW'(2);
    end else if (32'(cfg.group_size) > 32'(MAX_GROUP)) begin
      grp = GLW'(MAX_GROUP);
    end else begin
      grp = GLW'(cfg.group_size);
    end
  end

  always_comb begin
    first_byte = (column_pos == '0) && (row_pos == '0) && (pair_index == '0);
    skip_eff   = first_byte ? group_at_start : skip_first;
    diff       = (current_pixel > previous_pixel) ? current_pixel - previous_pixel
                                                  : previous_pixel - current_pixel;
    // sample only columns whose position modulo 32 is below 8
    hit        = (column_pos[4:3] == 2'b00) && (diff > cfg.noise_level);
    count_inc  = (hit && (running_count != '1)) ? running_count + 1'b1 : running_count;
    row_end    = (32'(column_pos) + 32'd1) >= 32'(cols);
    frame_end  = row_end && ((32'(row_pos) + 32'd1) >= 32'(rows));
    group_end  = frame_end && ((32'(pair_index) + 32'd1) >= 32'(grp));
  end

  // Minimum update at the end of a frame difference
  always_comb begin
    lowest_count_next = lowest_count;
    best_index_next   = best_index;
    skip_first_next   = skip_eff;
    if (pair_index == '0) begin
      if (!skip_eff) begin
        lowest_count_next = count_inc;
        best_index_next   = '0;
      end
    end else if (skip_eff && (pair_index == PW'(1))) begin
      lowest_count_next = count_inc;
      best_index_next   = PW'(1);
      skip_first_next   = 1'b0;
    end else if (count_inc < lowest_count) begin
      lowest_count_next = count_inc;
      best_index_next   = pair_index;
    end
  end

  always_comb begin
    push.push              = accept && group_end;
    push.job.lowest_count  = lowest_count_next;
    push.job.best_index    = dfd_pkg::DROP_W'(best_index_next);
    push.job.rows          = dfd_pkg::ROWS_CAP_W'(rows);
    push.job.cols          = dfd_pkg::COLS_CAP_W'(cols);
    push.job.blend_limit   = cfg.blend_limit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_pos    <= '0;
      row_pos       <= '0;
      pair_index    <= '0;
      running_count <= '0;
      lowest_count  <= '0;
      best_index    <= '0;
      skip_first    <= 1'b0;
    end else if (accept) begin
      if (!row_end) begin
        column_pos    <= column_pos + 1'b1;
        running_count <= count_inc;
        skip_first    <= skip_eff;
      end else if (!frame_end) begin
        column_pos    <= '0;
        row_pos       <= row_pos + 1'b1;
        running_count <= count_inc;
        skip_first    <= skip_eff;
      end else if (!group_end) begin
        column_pos    <= '0;
        row_pos       <= '0;
        pair_index    <= pair_index + 1'b1;
        running_count <= '0;
        lowest_count  <= lowest_count_next;
        best_index    <= best_index_next;
        skip_first    <= skip_first_next;
      end else begin
        column_pos    <= '0;
        row_pos       <= '0;
        pair_index    <= '0;
        running_count <= '0;
        lowest_count  <= '0;
        best_index    <= '0;
        skip_first    <= 1'b0;
      end
    end
  end

endmodule

/* hw/rtl/dfd_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfd_queue
// Short first-in first-out queue of group records between front and back.
// ----------------------------------------------------------------------------
module dfd_queue #(
  parameter int DEPTH = dfd_pkg::QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  dfd_pkg::push_t         push,
  input  logic                   pop,
  output dfd_pkg::queue_status_t status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  dfd_pkg::job_t    entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  always_comb begin
    status.not_empty = (fill != '0);
    status.full      = (fill == CNT_W'(DEPTH));
    status.job       = entries[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (push.push) begin
      entries[wr_ptr] <= push.job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push.push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push.push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push.push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

/* hw/rtl/dfd_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfd_back
// Turns a group record into the result item: scales the lowest count,
// divides by the frame size one quotient bit a cycle and holds the result.
// ----------------------------------------------------------------------------
module dfd_back (
  input  logic                          clk,
  input  logic                          rst,
  input  dfd_pkg::queue_status_t        status,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [dfd_pkg::DROP_W-1:0]    drop_offset,
  output logic [dfd_pkg::METRIC_W-1:0]  similarity_metric,
  output logic                          blend_allowed
);

  localparam int NUM_W = dfd_pkg::NUM_W;
  localparam int DEN_W = dfd_pkg::DEN_W;
  localparam int CNT_W = $clog2(NUM_W);

  dfd_pkg::back_state_t state;
  dfd_pkg::back_state_t state_next;

  logic [NUM_W-1:0]            quo;    // numerator, shifted out as quotient fills
  logic [DEN_W-1:0]            den;
  logic [DEN_W-1:0]            rem;
  logic [CNT_W-1:0]            step;
  logic [dfd_pkg::DROP_W-1:0]  index_hold;
  logic [dfd_pkg::BLEND_W-1:0] blend_hold;

  logic [DEN_W:0] trial;
  logic           fits;
  logic           do_mul;
  logic           do_div;
  logic           do_load;
  logic           out_free;

  assign out_free = !out_valid || !out_stall;
  assign trial    = {rem, quo[NUM_W-1]};
  assign fits     = trial >= {1'b0, den};

  always_comb begin
    state_next = state;
    unique case (state)
      dfd_pkg::BACK_IDLE: if (status.not_empty) state_next = dfd_pkg::BACK_MUL;
      dfd_pkg::BACK_MUL:  state_next = dfd_pkg::BACK_DIV;
      dfd_pkg::BACK_DIV:  if (step == CNT_W'(NUM_W - 1)) state_next = dfd_pkg::BACK_DONE;
      dfd_pkg::BACK_DONE: if (out_free) state_next = dfd_pkg::BACK_IDLE;
      default:            state_next = dfd_pkg::BACK_IDLE;
    endcase
  end

  always_comb begin
    pop     = 1'b0;
    do_mul  = 1'b0;
    do_div  = 1'b0;
    do_load = 1'b0;
    unique case (state)
      dfd_pkg::BACK_IDLE: ;
      dfd_pkg::BACK_MUL: begin
        pop    = 1'b1;
        do_mul = 1'b1;
      end
      dfd_pkg::BACK_DIV:  do_div = 1'b1;
      dfd_pkg::BACK_DONE: do_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dfd_pkg::BACK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Scale, then restoring division
  always_ff @(posedge clk) begin
    if (do_mul) begin
      quo        <= NUM_W'(status.job.lowest_count) * NUM_W'(dfd_pkg::METRIC_SCALE);
      den        <= DEN_W'(status.job.rows) * DEN_W'(status.job.cols);
      rem        <= '0;
      step       <= '0;
      index_hold <= status.job.best_index;
      blend_hold <= status.job.blend_limit;
    end else if (do_div) begin
      rem  <= fits ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
      quo  <= {quo[NUM_W-2:0], fits};
      step <= step + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_load) begin
      drop_offset       <= index_hold;
      similarity_metric <= quo[dfd_pkg::METRIC_W-1:0];
      blend_allowed     <= (blend_hold == '0) || (quo <= NUM_W'(blend_hold));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (do_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

/* hw/rtl/duplicate_frame_detector_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// duplicate_frame_detector_core
// Finds the frame most like its predecessor in each decimation group.
// ----------------------------------------------------------------------------
// The block takes one byte pair (current, previous) per cycle, row by row,
// frame_rows rows of row_bytes bytes per frame difference, group_size
// differences per group. After the last byte of a group it gives one item:
// the offset of the lowest difference, the metric lowest*100000/(rows*cols)
// and the blend-allowed flag. The front takes one item every cycle unless
// in_stall is high. Each group result then passes through the back: it is
// picked up from the queue and scaled, run through a one-bit-a-cycle
// divider and loaded into the output register; a two-entry queue holds
// finished groups meanwhile, so in_stall rises only when the queue is full,
// because groups arrive faster than the back finishes them or results are
// not taken. Write the registers only while the block is idle; geometry
// and group size are clamped to the supported range.
// ----------------------------------------------------------------------------
module duplicate_frame_detector_core #(
  parameter int MAX_ROW_BYTES = dfd_pkg::MAX_ROW_BYTES_DEF,
  parameter int MAX_ROWS      = dfd_pkg::MAX_ROWS_DEF,
  parameter int MAX_GROUP     = dfd_pkg::MAX_GROUP_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration
  input  logic                             cfg_we,
  input  logic [dfd_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [dfd_pkg::CFG_DATA_W-1:0]   cfg_data,
  // input items
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [dfd_pkg::PIXEL_W-1:0]      current_pixel,
  input  logic [dfd_pkg::PIXEL_W-1:0]      previous_pixel,
  input  logic                             group_at_start,
  // result items
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [dfd_pkg::DROP_W-1:0]       drop_offset,
  output logic [dfd_pkg::METRIC_W-1:0]     similarity_metric,
  output logic                             blend_allowed
);

  dfd_pkg::cfg_t          cfg;
  dfd_pkg::push_t         push;
  dfd_pkg::queue_status_t status;
  logic                   pop;
  logic                   accept;

  // Hold off the input while the queue has no room for a finished group
  assign in_stall = status.full;
  assign accept   = in_valid && !status.full;

  // Register file: truncate write data to each register's width
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.group_size  <= dfd_pkg::GROUP_SIZE_RST;
      cfg.row_bytes   <= dfd_pkg::ROW_BYTES_RST;
      cfg.frame_rows  <= dfd_pkg::FRAME_ROWS_RST;
      cfg.noise_level <= dfd_pkg::NOISE_LEVEL_RST;
      cfg.blend_limit <= dfd_pkg::BLEND_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dfd_pkg::REG_GROUP_SIZE:  cfg.group_size  <= cfg_data[dfd_pkg::GROUP_SIZE_W-1:0];
        dfd_pkg::REG_ROW_BYTES:   cfg.row_bytes   <= cfg_data[dfd_pkg::ROW_BYTES_W-1:0];
        dfd_pkg::REG_FRAME_ROWS:  cfg.frame_rows  <= cfg_data[dfd_pkg::FRAME_ROWS_W-1:0];
        dfd_pkg::REG_NOISE_LEVEL: cfg.noise_level <= cfg_data[dfd_pkg::NOISE_W-1:0];
        dfd_pkg::REG_BLEND_LIMIT: cfg.blend_limit <= cfg_data[dfd_pkg::BLEND_W-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Front: count, track the minimum, emit one record per group
  dfd_front #(
    .MAX_ROW_BYTES (MAX_ROW_BYTES),
    .MAX_ROWS      (MAX_ROWS),
    .MAX_GROUP     (MAX_GROUP)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .accept         (accept),
    .current_pixel  (current_pixel),
    .previous_pixel (previous_pixel),
    .group_at_start (group_at_start),
    .push           (push)
  );

  // Queue of finished groups
  dfd_queue #(
    .DEPTH (dfd_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .pop    (pop),
    .status (status)
  );

  // Back: scale, divide, present the result item
  dfd_back u_back (
    .clk               (clk),
    .rst               (rst),
    .status            (status),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .drop_offset       (drop_offset),
    .similarity_metric (similarity_metric),
    .blend_allowed     (blend_allowed)
  );

endmodule

/* sim/duplicate_frame_detector_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// duplicate_frame_detector_core_test
// Self-checking testbench for the duplicate frame detector core.
// ----------------------------------------------------------------------------
// Byte pairs stream into the core under random valid gaps and result stalls.
// A scoreboard object tracks row, frame and group position, the per-frame
// changed-byte count and the running minimum. At the end of each group it
// queues the offset, metric and blend flag that the core must give. Every
// result the core hands over is compared field by field with the oldest
// queued verdict. The run opens with a few hand-picked groups. It then
// backs the core up with a long result stall and runs out-of-range
// settings once. Most of the run is random short groups under changing
// register settings.
// ----------------------------------------------------------------------------
module duplicate_frame_detector_core_test;
  import dfd_pkg::*;

  localparam int unsigned RANDOM_ITEMS  = 750;
  localparam int unsigned STEADY_ITEMS  = 200;   // tail of the run with no idling
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned STALL_LIMIT   = 5000;

  typedef enum logic [1:0] {
    MIX_RANDOM,
    MIX_QUIET,
    MIX_THRESHOLD,
    MIX_EXTREME
  } pixel_mix_t;

  typedef struct packed {
    logic [DROP_W-1:0]   drop;
    logic [METRIC_W-1:0] metric;
    logic                allow;
  } verdict_t;

  // --------------------------------------------------------------------------
  // Scoreboard: mirrors the core's counters and holds the verdicts it owes
  // --------------------------------------------------------------------------
  class verdict_scoreboard;
    logic [GROUP_SIZE_W-1:0] group_size;
    logic [ROW_BYTES_W-1:0]  row_bytes;
    logic [FRAME_ROWS_W-1:0] frame_rows;
    logic [NOISE_W-1:0]      noise_level;
    logic [BLEND_W-1:0]      blend_limit;
    int unsigned             column_pos, row_pos, pair_index;
    logic [COUNT_W-1:0]      running_count, lowest_count;
    logic [DROP_W-1:0]       best_index;
    bit                      skip_first;
    verdict_t                verdicts_due[$];
    int unsigned             verdicts_checked, mismatches;

    function new();
      group_size       = GROUP_SIZE_RST;
      row_bytes        = ROW_BYTES_RST;
      frame_rows       = FRAME_ROWS_RST;
      noise_level      = NOISE_LEVEL_RST;
      blend_limit      = BLEND_LIMIT_RST;
      column_pos       = 0;
      row_pos          = 0;
      pair_index       = 0;
      running_count    = '0;
      lowest_count     = '0;
      best_index       = '0;
      skip_first       = 1'b0;
      verdicts_checked = 0;
      mismatches       = 0;
    endfunction

    function int unsigned clamp_to(int unsigned v, int unsigned lo, int unsigned hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function void take_setting(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_GROUP_SIZE:  group_size  = data[GROUP_SIZE_W-1:0];
        REG_ROW_BYTES:   row_bytes   = data[ROW_BYTES_W-1:0];
        REG_FRAME_ROWS:  frame_rows  = data[FRAME_ROWS_W-1:0];
        REG_NOISE_LEVEL: noise_level = data[NOISE_W-1:0];
        REG_BLEND_LIMIT: blend_limit = data[BLEND_W-1:0];
        default: ;
      endcase
    endfunction

    // Byte pairs in one whole group under the current settings
    function int unsigned group_span();
      return clamp_to(group_size, 2, MAX_GROUP_DEF) *
             clamp_to(frame_rows, 1, MAX_ROWS_DEF) *
             clamp_to(row_bytes, 1, MAX_ROW_BYTES_DEF);
    endfunction

    function void absorb_pair(logic [PIXEL_W-1:0] cur, logic [PIXEL_W-1:0] prv,
                              logic at_start);
      int unsigned     cols, rows, grp, gap;
      longint unsigned scaled;
      verdict_t        v;
      cols = clamp_to(row_bytes, 1, MAX_ROW_BYTES_DEF);
      rows = clamp_to(frame_rows, 1, MAX_ROWS_DEF);
      grp  = clamp_to(group_size, 2, MAX_GROUP_DEF);

      // latch the start-of-clip flag on the first byte of a group
      if (column_pos == 0 && row_pos == 0 && pair_index == 0)
        skip_first = at_start;

      // only the first 8 columns of every 32 are sampled
      if ((column_pos % 32) < 8) begin
        gap = (cur > prv) ? int'(cur) - int'(prv) : int'(prv) - int'(cur);
        if (gap > noise_level && running_count != '1)
          running_count = running_count + 1'b1;
      end

      column_pos++;
      if (column_pos < cols) return;
      column_pos = 0;
      row_pos++;
      if (row_pos < rows) return;
      row_pos = 0;

      // one frame difference done: fold it into the minimum
      if (pair_index == 0) begin
        if (!skip_first) begin
          lowest_count = running_count;
          best_index   = '0;
        end
      end else if (skip_first && pair_index == 1) begin
        lowest_count = running_count;
        best_index   = DROP_W'(1);
        skip_first   = 1'b0;
      end else if (running_count < lowest_count) begin
        lowest_count = running_count;
        best_index   = DROP_W'(pair_index);
      end
      running_count = '0;
      pair_index++;
      if (pair_index < grp) return;

      // group done: queue the verdict
      scaled   = (64'(lowest_count) * 64'(METRIC_SCALE)) / (64'(rows) * 64'(cols));
      v.drop   = best_index;
      v.metric = scaled[METRIC_W-1:0];
      v.allow  = (blend_limit == '0) || (scaled <= 64'(blend_limit));
      verdicts_due.push_back(v);
      pair_index   = 0;
      lowest_count = '0;
      best_index   = '0;
      skip_first   = 1'b0;
    endfunction

    function void check_verdict(logic [DROP_W-1:0] drop, logic [METRIC_W-1:0] metric,
                                logic allow);
      verdict_t v;
      if (verdicts_due.size() == 0) begin
        $error("result with nothing due: drop_offset %0d similarity_metric %0d",
               drop, metric);
        mismatches++;
        return;
      end
      v = verdicts_due.pop_front();
      verdicts_checked++;
      if (drop !== v.drop) begin
        $error("drop_offset: expected %0d, got %0d", v.drop, drop);
        mismatches++;
      end
      if (metric !== v.metric) begin
        $error("similarity_metric: expected %0d, got %0d", v.metric, metric);
        mismatches++;
      end
      if (allow !== v.allow) begin
        $error("blend_allowed: expected %0d, got %0d", v.allow, allow);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return verdicts_due.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT and clock
  // --------------------------------------------------------------------------
  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   in_valid;
  logic                   in_stall;
  logic [PIXEL_W-1:0]     current_pixel;
  logic [PIXEL_W-1:0]     previous_pixel;
  logic                   group_at_start;
  logic                   out_valid;
  logic                   out_stall;
  logic [DROP_W-1:0]      drop_offset;
  logic [METRIC_W-1:0]    similarity_metric;
  logic                   blend_allowed;

  verdict_scoreboard board;

  int unsigned gap_pct      = 0;    // sender idling, percent per item
  int unsigned sink_pct     = 0;    // receiver stalling, percent per cycle
  bit          steady       = 1'b0; // tail of the run: no idling at all
  bit          hold_request = 1'b0; // ask the receiver for one long hold-off
  int unsigned dead_cycles  = 0;

  duplicate_frame_detector_core u_dut (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .current_pixel     (current_pixel),
    .previous_pixel    (previous_pixel),
    .group_at_start    (group_at_start),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .drop_offset       (drop_offset),
    .similarity_metric (similarity_metric),
    .blend_allowed     (blend_allowed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Monitor: sample both handshakes on the edge and feed the scoreboard
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall)
      board.absorb_pair(current_pixel, previous_pixel, group_at_start);
    if (!rst && out_valid && !out_stall)
      board.check_verdict(drop_offset, similarity_metric, blend_allowed);
  end

  // Watchdog: give up once neither side has moved an item for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      dead_cycles <= 0;
    else
      dead_cycles <= dead_cycles + 1;
    if (dead_cycles >= STALL_LIMIT) begin
      $display("[duplicate_frame_detector_core] ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stall bursts, plus one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : result_sink
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        // hold results back long enough for the queue to fill and the
        // core to push back on its input
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!steady && sink_pct != 0 && $urandom_range(0, 99) < sink_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driver tasks
  // --------------------------------------------------------------------------

  // Offer one item, optionally after an idle burst, and hold it until taken
  task automatic feed(input logic [PIXEL_W-1:0] cur, input logic [PIXEL_W-1:0] prv,
                      input logic at_start);
    if (!steady && gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    current_pixel  <= cur;
    previous_pixel <= prv;
    group_at_start <= at_start;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid, wait for every owed verdict, then let the back end go quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic poke_reg(input logic [CFG_INDEX_W-1:0] idx, input int unsigned value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_DATA_W-1:0];
    @(posedge clk);
    board.take_setting(idx, value[CFG_DATA_W-1:0]);
  endtask

  task automatic apply_settings(input int unsigned grp, input int unsigned cols,
                                input int unsigned rows, input int unsigned noise,
                                input int unsigned blend);
    poke_reg(REG_GROUP_SIZE, grp);
    poke_reg(REG_ROW_BYTES, cols);
    poke_reg(REG_FRAME_ROWS, rows);
    poke_reg(REG_NOISE_LEVEL, noise);
    poke_reg(REG_BLEND_LIMIT, blend);
    cfg_we <= 1'b0;
  endtask

  // Build one byte pair in the requested style
  function automatic void make_pair(input pixel_mix_t mix, input int unsigned noise,
                                    output logic [PIXEL_W-1:0] cur,
                                    output logic [PIXEL_W-1:0] prv);
    int unsigned base, delta;
    base = $urandom_range(0, 255);
    case (mix)
      MIX_RANDOM: begin
        prv = PIXEL_W'(base);
        cur = PIXEL_W'($urandom_range(0, 255));
      end
      MIX_QUIET: begin
        // mostly identical bytes with the odd real change
        prv = PIXEL_W'(base);
        cur = ($urandom_range(0, 7) == 0) ? PIXEL_W'($urandom_range(0, 255)) : prv;
      end
      MIX_THRESHOLD: begin
        // difference one below, at or one above the noise level
        delta = noise + $urandom_range(0, 2);
        delta = (delta == 0) ? 0 : delta - 1;
        if (delta > 255) delta = 255;
        if (base + delta <= 255) begin
          prv = PIXEL_W'(base);
          cur = PIXEL_W'(base + delta);
        end else if (base >= delta) begin
          prv = PIXEL_W'(base);
          cur = PIXEL_W'(base - delta);
        end else begin
          prv = PIXEL_W'(255 - delta);
          cur = 8'hFF;
        end
      end
      default: begin
        cur = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        prv = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
    endcase
  endfunction

  // Program one setting, then stream whole groups plus an optional partial
  // tail; a tail leaves the next setting to land part-way through a group
  task automatic run_phase(input int unsigned grp, input int unsigned cols,
                           input int unsigned rows, input int unsigned noise,
                           input int unsigned blend, input pixel_mix_t mix,
                           input int unsigned groups, input int unsigned partial,
                           input bit scatter_start);
    int unsigned        span, total;
    logic [PIXEL_W-1:0] cur, prv;
    logic               at_start;
    settle();
    apply_settings(grp, cols, rows, noise, blend);
    span     = board.group_span();
    total    = groups * span + partial;
    at_start = 1'b0;
    for (int unsigned i = 0; i < total; i++) begin
      // hold the start-of-clip flag over a group, or scramble it as noise
      if (scatter_start || (i % span) == 0)
        at_start = 1'($urandom_range(0, 1));
      make_pair(mix, noise, cur, prv);
      feed(cur, prv, at_start);
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned random_fed;
    int unsigned grp, cols, rows, noise, blend, groups, partial, pick;
    pixel_mix_t  mix;

    board          = new();
    random_fed     = 0;
    rst            <= 1'b1;
    cfg_we         <= 1'b0;
    cfg_index      <= REG_GROUP_SIZE;
    cfg_data       <= '0;
    in_valid       <= 1'b0;
    current_pixel  <= '0;
    previous_pixel <= '0;
    group_at_start <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Hand-picked groups of two single-byte frames, every byte counts
    apply_settings(2, 1, 1, 0, 0);
    feed(8'h00, 8'h00, 1'b1);  // start of clip: frame 0 ignored
    feed(8'h00, 8'h00, 1'b1);
    feed(8'hFF, 8'h00, 1'b0);  // later frame wins on a lower count
    feed(8'h00, 8'h00, 1'b0);
    feed(8'hFF, 8'h00, 1'b0);  // tie: earliest index wins, full metric
    feed(8'h00, 8'hFF, 1'b0);
    feed(8'h00, 8'h00, 1'b0);  // flag only counts on the first byte
    feed(8'hFF, 8'hFF, 1'b1);
    feed(8'h00, 8'hFF, 1'b1);  // start of clip with a busy frame 0
    feed(8'hFF, 8'h00, 1'b0);
    settle();

    // Noise level just under its top end and a blend limit just under full scale
    apply_settings(2, 1, 1, 254, 99999);
    feed(8'hFF, 8'h00, 1'b0);  // metric 100000 above the limit: no blend
    feed(8'h00, 8'hFF, 1'b0);
    feed(8'hFE, 8'h00, 1'b0);  // difference equal to noise does not count
    feed(8'h00, 8'h00, 1'b0);
    settle();

    // Back the core up: long result hold-off while the sender keeps going
    gap_pct      = 0;
    sink_pct     = 0;
    hold_request = 1'b1;
    run_phase(2, 1, 1, 0, 0, MIX_RANDOM, 40, 0, 1'b0);

    // Out-of-range settings and rows wider than a sample window, one or two groups
    gap_pct  = 5;
    sink_pct = 5;
    run_phase(1, 40, 0, 0, 1, MIX_RANDOM, 1, 0, 1'b0);
    run_phase(2, 48, 1, 128, 131071, MIX_THRESHOLD, 1, 0, 1'b0);
    run_phase(2, 0, 24, 200, 0, MIX_EXTREME, 1, 0, 1'b0);
    run_phase(2, 1, 24, 15, 100000, MIX_QUIET, 1, 0, 1'b0);
    run_phase(31, 1, 1, 0, 0, MIX_RANDOM, 2, 0, 1'b0);
    run_phase(25, 2, 1, 3, 50000, MIX_QUIET, 1, 0, 1'b0);

    // Random settings and content, mostly short well-formed groups
    while (random_fed < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick < 6)       grp = $urandom_range(2, 4);
      else if (pick < 8)  grp = $urandom_range(5, 31);
      else if (pick == 8) grp = $urandom_range(0, 1);
      else                grp = 25;

      pick = $urandom_range(0, 19);
      if (pick < 14)      cols = $urandom_range(1, 8);
      else if (pick < 19) cols = $urandom_range(9, 64);
      else                cols = 0;

      pick = $urandom_range(0, 19);
      if (pick < 16)      rows = 1;
      else if (pick < 19) rows = $urandom_range(2, 3);
      else                rows = 0;

      // keep a group short
      if (grp * (rows == 0 ? 1 : rows) * (cols == 0 ? 1 : cols) > 120)
        cols = $urandom_range(1, 2);

      pick = $urandom_range(0, 9);
      if (pick < 2)       noise = 0;
      else if (pick == 2) noise = 255;
      else                noise = $urandom_range(0, 255);

      pick = $urandom_range(0, 9);
      if (pick < 4)       blend = 0;
      else if (pick == 4) blend = 100000;
      else if (pick == 5) blend = 131071;
      else                blend = $urandom_range(0, 100000);

      mix     = pixel_mix_t'($urandom_range(0, 3));
      groups  = $urandom_range(1, 4);
      partial = ($urandom_range(0, 9) < 3) ? $urandom_range(1, 20) : 0;

      steady = (random_fed + STEADY_ITEMS >= RANDOM_ITEMS);
      if (steady) begin
        gap_pct  = 0;
        sink_pct = 0;
      end else begin
        pick     = $urandom_range(0, 2);
        gap_pct  = (pick == 0) ? 0 : (pick == 1) ? 10 : 30;
        pick     = $urandom_range(0, 2);
        sink_pct = (pick == 0) ? 0 : (pick == 1) ? 10 : 30;
      end

      run_phase(grp, cols, rows, noise, blend, mix, groups, partial,
                $urandom_range(0, 99) < 15);
      random_fed += groups * board.group_span() + partial;
    end

    settle();
    if (board.mismatches == 0 && board.pending() == 0)
      $display("[duplicate_frame_detector_core] OK");
    else
      $display("[duplicate_frame_detector_core] ERROR");
    $finish;
  end

endmodule

/* duplicate_frame_detector_core.f */
hw/rtl/dfd_pkg.sv
hw/rtl/dfd_front.sv
hw/rtl/dfd_queue.sv
hw/rtl/dfd_back.sv
hw/rtl/duplicate_frame_detector_core.sv
sim/duplicate_frame_detector_core_test.sv
